// ===== rtl/ppal_pkg.sv =====
// ----------------------------------------------------------------------------
// ppal_pkg: shared types and constants for path point at arc length
// Operation codes, datapath widths and the segment length unit interface.
// ----------------------------------------------------------------------------
package ppal_pkg;

	localparam int MAX_POINTS_DEF = 256;
	localparam int COORD_W = 32;            // Q16.16 coordinate
	localparam int DIFF_W  = COORD_W + 1;   // coordinate difference
	localparam int LEN_W   = DIFF_W;        // segment length
	localparam int RAT_W   = 32;            // Q1.31 ratio
	localparam int PROD_W  = 64;            // |delta| * ratio

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_QUERY  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef struct packed {
		logic              start;
		logic [DIFF_W-1:0] ax;
		logic [DIFF_W-1:0] ay;
	} seg_req_t;

	typedef struct packed {
		logic             done;
		logic [LEN_W-1:0] len;
	} seg_rsp_t;

	function automatic logic [DIFF_W-1:0] mag_diff(input logic [DIFF_W-1:0] v);
		return v[DIFF_W-1] ? (~v + DIFF_W'(1)) : v;
	endfunction

endpackage

// ===== rtl/ppal_seglen.sv =====
// ----------------------------------------------------------------------------
// ppal_seglen: serial planar segment length
// floor(sqrt(ax^2 + ay^2)): shift-add squares one bit per cycle, then a
// digit-by-digit square root two bits per cycle.
// ----------------------------------------------------------------------------
module ppal_seglen (
	input  logic              clk,
	input  logic              arst_n,
	input  ppal_pkg::seg_req_t req,
	output ppal_pkg::seg_rsp_t rsp
);
	import ppal_pkg::*;

	localparam int SQ_W  = 2 * DIFF_W;
	localparam int REM_W = LEN_W + 3;

	typedef enum logic [2:0] {
		SL_IDLE = 3'b001,
		SL_SQ   = 3'b010,
		SL_RT   = 3'b100
	} sl_state_t;

	sl_state_t          state_q;
	logic [5:0]         cnt_q;
	logic [SQ_W-1:0]    mx_q, my_q, val_q;
	logic [DIFF_W-1:0]  bx_q, by_q;
	logic [LEN_W-1:0]   root_q;
	logic [REM_W-1:0]   rem_q;
	logic               done_q;

	logic [SQ_W-1:0]  add_x, add_y, sum_next;
	logic [REM_W-1:0] rem_sh, trial;
	logic             ge;

	assign add_x    = bx_q[0] ? mx_q : '0;
	assign add_y    = by_q[0] ? my_q : '0;
	assign sum_next = val_q + add_x + add_y;
	assign rem_sh   = {rem_q[REM_W-3:0], val_q[SQ_W-1 -: 2]};
	assign trial    = {1'b0, root_q, 2'b01};
	assign ge       = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SL_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				SL_IDLE: begin
					if (req.start) begin
						mx_q    <= {{DIFF_W{1'b0}}, req.ax};
						my_q    <= {{DIFF_W{1'b0}}, req.ay};
						bx_q    <= req.ax;
						by_q    <= req.ay;
						val_q   <= '0;
						cnt_q   <= '0;
						state_q <= SL_SQ;
					end
				end
				SL_SQ: begin
					val_q <= sum_next;
					mx_q  <= {mx_q[SQ_W-2:0], 1'b0};
					my_q  <= {my_q[SQ_W-2:0], 1'b0};
					bx_q  <= bx_q >> 1;
					by_q  <= by_q >> 1;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(DIFF_W - 1)) begin
						cnt_q   <= '0;
						root_q  <= '0;
						rem_q   <= '0;
						state_q <= SL_RT;
					end
				end
				SL_RT: begin
					val_q  <= {val_q[SQ_W-3:0], 2'b00};
					rem_q  <= ge ? (rem_sh - trial) : rem_sh;
					root_q <= {root_q[LEN_W-2:0], ge};
					cnt_q  <= cnt_q + 6'd1;
					if (cnt_q == 6'(LEN_W - 1)) begin
						done_q  <= 1'b1;
						state_q <= SL_IDLE;
					end
				end
				default: state_q <= SL_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.len  = root_q;

endmodule

// ===== rtl/path_point_at_arc_length.sv =====
// ----------------------------------------------------------------------------
// path_point_at_arc_length: point on a stored 3-D path at a planar arc length
// Holds a polyline of Q16.16 points; clear, append and query words.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready) carries one word: operation plus
//    point_x/y/z (append) or query_distance (query). Clear and append take
//    effect in the accept cycle and produce no output word.
//  - Output channel (out_valid/out_ready) returns one word per query.
//  - in_ready is high only while the sequencer is idle; a query keeps it
//    low until its result sits in the output register.
//  - An empty-path query goes straight to the done state; a non-positive
//    distance or a one-point path returns the first point after its read.
//    Otherwise each walked segment is read from the point memories, its
//    length taken from the serial length unit (squares, then root) and
//    its result taken, and the final segment adds a bit-serial divide and
//    multiply.
//  - The point memories are read one entry per segment.
//  - Reset empties the path and clears the overflow flag; stored points
//    are not cleared and only entries below the count are ever read.
//  - When the receiver stalls, the result holds in the output register;
//    clears and appends are still taken meanwhile, and a finished query
//    waits in its last state until the output register frees.
// ----------------------------------------------------------------------------
module path_point_at_arc_length #(
	parameter int MAX_POINTS = ppal_pkg::MAX_POINTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	input  logic signed [31:0] query_distance,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [31:0] target_x,
	output logic signed [31:0] target_y,
	output logic signed [31:0] target_z,
	output logic        path_empty,
	output logic        path_overflowed
);
	import ppal_pkg::*;

	localparam int CW   = $clog2(MAX_POINTS + 1);
	localparam int AW   = $clog2(MAX_POINTS);
	localparam int ACCW = LEN_W + AW;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_RD   = 8'b0000_0010,
		ST_LOAD = 8'b0000_0100,
		ST_LEN  = 8'b0000_1000,
		ST_DIV  = 8'b0001_0000,
		ST_MUL  = 8'b0010_0000,
		ST_FIN  = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} state_t;

	// point memories
	logic [COORD_W-1:0] mem_x [MAX_POINTS];
	logic [COORD_W-1:0] mem_y [MAX_POINTS];
	logic [COORD_W-1:0] mem_z [MAX_POINTS];
	logic [COORD_W-1:0] rd_x_q, rd_y_q, rd_z_q;

	state_t             state_q;
	logic [CW-1:0]      count_q, idx_q;
	logic               ovf_q, first_q, dpos_q;
	logic [30:0]        dist_q;
	logic [COORD_W-1:0] prev_x_q, prev_y_q, prev_z_q;
	logic [DIFF_W-1:0]  dx_q, dy_q, dz_q;
	logic [ACCW-1:0]    acc_q;
	logic [LEN_W-1:0]   len_q;
	logic [LEN_W:0]     rem_q;
	logic [RAT_W-1:0]   ratio_q;
	logic [5:0]         dcnt_q;
	logic [PROD_W-1:0]  mx_q, my_q, mz_q, px_q, py_q, pz_q;
	logic [COORD_W-1:0] res_x_q, res_y_q, res_z_q;
	logic               res_empty_q;
	logic               out_valid_q, out_empty_q, out_ovf_q;
	logic [COORD_W-1:0] out_x_q, out_y_q, out_z_q;

	logic              in_acc, wr_en, full, last_seg, done_fire;
	logic [DIFF_W-1:0] dxn, dyn, dzn;
	logic [ACCW-1:0]   sumlen;
	logic [LEN_W:0]    r2;
	logic              qbit;
	logic [PROD_W-1:0] rx, ry, rz;
	logic [DIFF_W-1:0] offx, offy, offz;
	seg_req_t          seg_req;
	seg_rsp_t          seg_rsp;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign full      = (count_q >= CW'(MAX_POINTS));
	assign wr_en     = in_acc && (op_t'(operation) == OP_APPEND) && !full;
	assign last_seg  = ((idx_q + CW'(1)) == count_q);
	assign done_fire = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_x[count_q[AW-1:0]] <= point_x;
			mem_y[count_q[AW-1:0]] <= point_y;
			mem_z[count_q[AW-1:0]] <= point_z;
		end
		rd_x_q <= mem_x[idx_q[AW-1:0]];
		rd_y_q <= mem_y[idx_q[AW-1:0]];
		rd_z_q <= mem_z[idx_q[AW-1:0]];
	end

	assign dxn = {rd_x_q[COORD_W-1], rd_x_q} - {prev_x_q[COORD_W-1], prev_x_q};
	assign dyn = {rd_y_q[COORD_W-1], rd_y_q} - {prev_y_q[COORD_W-1], prev_y_q};
	assign dzn = {rd_z_q[COORD_W-1], rd_z_q} - {prev_z_q[COORD_W-1], prev_z_q};

	assign seg_req.start = (state_q == ST_LOAD) && !first_q && ((dxn != '0) || (dyn != '0));
	assign seg_req.ax    = mag_diff(dxn);
	assign seg_req.ay    = mag_diff(dyn);

	ppal_seglen u_seglen (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (seg_req),
		.rsp    (seg_rsp)
	);

	assign sumlen = acc_q + ACCW'(seg_rsp.len);

	// restoring divide, first step without shift
	assign r2   = (dcnt_q == '0) ? rem_q : {rem_q[LEN_W-1:0], 1'b0};
	assign qbit = r2 >= {1'b0, len_q};

	// round half away from zero on the magnitude, then drop 31 fraction bits
	assign rx   = px_q + PROD_W'(64'h4000_0000);
	assign ry   = py_q + PROD_W'(64'h4000_0000);
	assign rz   = pz_q + PROD_W'(64'h4000_0000);
	assign offx = rx[PROD_W-1 -: DIFF_W];
	assign offy = ry[PROD_W-1 -: DIFF_W];
	assign offz = rz[PROD_W-1 -: DIFF_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			first_q     <= 1'b0;
			dcnt_q      <= '0;
		end else begin
			if (done_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (op_t'(operation))
							OP_CLEAR: begin
								count_q <= '0;
								ovf_q   <= 1'b0;
							end
							OP_APPEND: begin
								if (full) ovf_q <= 1'b1;
								else count_q <= count_q + CW'(1);
							end
							OP_QUERY: begin
								if (count_q == '0) begin
									res_x_q     <= '0;
									res_y_q     <= '0;
									res_z_q     <= '0;
									res_empty_q <= 1'b1;
									state_q     <= ST_DONE;
								end else begin
									idx_q   <= '0;
									first_q <= 1'b1;
									dist_q  <= query_distance[30:0];
									dpos_q  <= !query_distance[31] && (query_distance != '0);
									acc_q   <= '0;
									state_q <= ST_RD;
								end
							end
							default: ;
						endcase
					end
				end
				ST_RD: state_q <= ST_LOAD;
				ST_LOAD: begin
					res_empty_q <= 1'b0;
					if (first_q) begin
						first_q  <= 1'b0;
						prev_x_q <= rd_x_q;
						prev_y_q <= rd_y_q;
						prev_z_q <= rd_z_q;
						if (!dpos_q || last_seg) begin
							res_x_q <= rd_x_q;
							res_y_q <= rd_y_q;
							res_z_q <= rd_z_q;
							state_q <= ST_DONE;
						end else begin
							idx_q   <= CW'(1);
							state_q <= ST_RD;
						end
					end else if ((dxn == '0) && (dyn == '0)) begin
						// no planar extent: skip segment
						prev_x_q <= rd_x_q;
						prev_y_q <= rd_y_q;
						prev_z_q <= rd_z_q;
						idx_q    <= idx_q + CW'(1);
						res_x_q  <= rd_x_q;
						res_y_q  <= rd_y_q;
						res_z_q  <= rd_z_q;
						state_q  <= last_seg ? ST_DONE : ST_RD;
					end else begin
						dx_q    <= dxn;
						dy_q    <= dyn;
						dz_q    <= dzn;
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					if (seg_rsp.done) begin
						if ((seg_rsp.len != '0) && (sumlen >= ACCW'(dist_q))) begin
							rem_q   <= (LEN_W + 1)'(ACCW'(dist_q) - acc_q);
							len_q   <= seg_rsp.len;
							ratio_q <= '0;
							dcnt_q  <= '0;
							state_q <= ST_DIV;
						end else begin
							acc_q    <= sumlen;
							prev_x_q <= rd_x_q;
							prev_y_q <= rd_y_q;
							prev_z_q <= rd_z_q;
							idx_q    <= idx_q + CW'(1);
							res_x_q  <= rd_x_q;
							res_y_q  <= rd_y_q;
							res_z_q  <= rd_z_q;
							state_q  <= last_seg ? ST_DONE : ST_RD;
						end
					end
				end
				ST_DIV: begin
					rem_q   <= qbit ? (r2 - {1'b0, len_q}) : r2;
					ratio_q <= {ratio_q[RAT_W-2:0], qbit};
					dcnt_q  <= dcnt_q + 6'd1;
					if (dcnt_q == 6'(RAT_W - 1)) begin
						dcnt_q  <= '0;
						mx_q    <= PROD_W'(mag_diff(dx_q));
						my_q    <= PROD_W'(mag_diff(dy_q));
						mz_q    <= PROD_W'(mag_diff(dz_q));
						px_q    <= '0;
						py_q    <= '0;
						pz_q    <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (ratio_q[0]) begin
						px_q <= px_q + mx_q;
						py_q <= py_q + my_q;
						pz_q <= pz_q + mz_q;
					end
					mx_q    <= {mx_q[PROD_W-2:0], 1'b0};
					my_q    <= {my_q[PROD_W-2:0], 1'b0};
					mz_q    <= {mz_q[PROD_W-2:0], 1'b0};
					ratio_q <= ratio_q >> 1;
					dcnt_q  <= dcnt_q + 6'd1;
					if (dcnt_q == 6'(RAT_W - 1)) begin
						dcnt_q  <= '0;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					res_x_q <= dx_q[DIFF_W-1] ? (prev_x_q - offx[COORD_W-1:0])
						: (prev_x_q + offx[COORD_W-1:0]);
					res_y_q <= dy_q[DIFF_W-1] ? (prev_y_q - offy[COORD_W-1:0])
						: (prev_y_q + offy[COORD_W-1:0]);
					res_z_q <= dz_q[DIFF_W-1] ? (prev_z_q - offz[COORD_W-1:0])
						: (prev_z_q + offz[COORD_W-1:0]);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (done_fire) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register, loaded as the query retires
	always_ff @(posedge clk) begin
		if (done_fire) begin
			out_x_q     <= res_x_q;
			out_y_q     <= res_y_q;
			out_z_q     <= res_z_q;
			out_empty_q <= res_empty_q;
			out_ovf_q   <= ovf_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign target_x        = out_x_q;
	assign target_y        = out_y_q;
	assign target_z        = out_z_q;
	assign path_empty      = out_empty_q;
	assign path_overflowed = out_ovf_q;

endmodule

// ===== rtl/ppal_chk.sv =====
// ----------------------------------------------------------------------------
// ppal_chk: port-level checks for path_point_at_arc_length
// Watches the handshakes and result words; bound to the top level.
// ----------------------------------------------------------------------------
module ppal_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  operation,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] target_x,
	input logic [31:0] target_y,
	input logic [31:0] target_z,
	input logic        path_empty
);
	import ppal_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(target_x) && $stable(target_y)
			&& $stable(target_z) && $stable(path_empty))
		else $error("output word changed while stalled");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && path_empty |-> target_x == '0 && target_y == '0 && target_z == '0)
		else $error("empty path result has nonzero coordinates");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && operation == OP_QUERY |=> !in_ready)
		else $error("query did not occupy the sequencer");

endmodule

bind path_point_at_arc_length ppal_chk u_ppal_chk (.*);

// ===== tb/sv/path_point_at_arc_length_chk.sv =====
// ----------------------------------------------------------------------------
// path_point_at_arc_length_chk: result checker for path point at arc length
// Watches both channels, keeps its own copy of the path, predicts each query
// result and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module path_point_at_arc_length_chk
	import ppal_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [1:0]         operation,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	input  logic signed [31:0] query_distance,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] target_x,
	input  logic signed [31:0] target_y,
	input  logic signed [31:0] target_z,
	input  logic               path_empty,
	input  logic               path_overflowed,
	output int                 fail_count,
	output int                 pending
);

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               empty;
		logic               ovf;
	} target_t;

	logic signed [31:0] path_x [MAX_POINTS];
	logic signed [31:0] path_y [MAX_POINTS];
	logic signed [31:0] path_z [MAX_POINTS];
	int                 n_points;
	logic               dropped;
	target_t            targets_due [$];

	// floor(sqrt(v)), digit by digit
	function automatic logic [32:0] seg_root(input logic [65:0] v);
		logic [67:0] root;
		logic [67:0] rem;
		logic [67:0] trial;
		root = '0;
		rem  = '0;
		for (int k = 32; k >= 0; k--) begin
			rem   = (rem << 2) | 68'((v >> (2 * k)) & 66'd3);
			trial = (root << 2) | 68'd1;
			if (rem >= trial) begin
				rem  = rem - trial;
				root = (root << 1) | 68'd1;
			end else begin
				root = root << 1;
			end
		end
		return root[32:0];
	endfunction

	// a + delta*ratio/2^31, rounded half away from zero
	function automatic logic signed [31:0] blend(input logic signed [31:0] a,
			input logic signed [32:0] delta, input logic [31:0] ratio);
		logic [32:0] mag;
		logic [95:0] off;
		logic signed [34:0] res;
		mag = delta[32] ? 33'(-delta) : 33'(delta);
		off = (96'(mag) * 96'(ratio) + (96'd1 << 30)) >> 31;
		res = delta[32] ? 35'(a) - 35'(off) : 35'(a) + 35'(off);
		return res[31:0];
	endfunction

	function automatic target_t locate(input logic signed [31:0] d);
		target_t t;
		logic [63:0] want;
		logic [63:0] walked;
		logic signed [32:0] dx, dy, dz;
		logic [32:0] ax, ay, seg_len;
		logic [95:0] ratio;
		t = '0;
		t.ovf = dropped;
		if (n_points == 0) begin
			t.empty = 1'b1;
			return t;
		end
		if (d <= 0) begin
			t.x = path_x[0]; t.y = path_y[0]; t.z = path_z[0];
			return t;
		end
		want   = 64'(d);
		walked = '0;
		for (int i = 1; i < n_points; i++) begin
			dx = 33'(path_x[i]) - 33'(path_x[i-1]);
			dy = 33'(path_y[i]) - 33'(path_y[i-1]);
			dz = 33'(path_z[i]) - 33'(path_z[i-1]);
			ax = dx[32] ? 33'(-dx) : 33'(dx);
			ay = dy[32] ? 33'(-dy) : 33'(dy);
			seg_len = seg_root(66'(ax) * 66'(ax) + 66'(ay) * 66'(ay));
			if (seg_len == 0)
				continue;
			if (walked + 64'(seg_len) >= want) begin
				ratio = (96'(want - walked) << 31) / 96'(seg_len);
				if (ratio > (96'd1 << 31))
					ratio = 96'd1 << 31;
				t.x = blend(path_x[i-1], dx, ratio[31:0]);
				t.y = blend(path_y[i-1], dy, ratio[31:0]);
				t.z = blend(path_z[i-1], dz, ratio[31:0]);
				return t;
			end
			walked = walked + 64'(seg_len);
		end
		t.x = path_x[n_points-1];
		t.y = path_y[n_points-1];
		t.z = path_z[n_points-1];
		return t;
	endfunction

	assign pending = targets_due.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_points   <= 0;
			dropped    <= 1'b0;
			fail_count <= 0;
			targets_due.delete();
		end else begin
			if (in_valid && in_ready) begin
				case (op_t'(operation))
				OP_CLEAR: begin
					n_points <= 0;
					dropped  <= 1'b0;
				end
				OP_APPEND: begin
					if (n_points >= MAX_POINTS) begin
						dropped <= 1'b1;
					end else begin
						path_x[n_points] <= point_x;
						path_y[n_points] <= point_y;
						path_z[n_points] <= point_z;
						n_points <= n_points + 1;
					end
				end
				OP_QUERY: targets_due.push_back(locate(query_distance));
				default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				target_t e;
				if (targets_due.size() == 0) begin
					$display("%0t: unexpected word x=%h y=%h z=%h", $time,
						target_x, target_y, target_z);
					fail_count <= fail_count + 1;
				end else begin
					e = targets_due.pop_front();
					if (e.x !== target_x || e.y !== target_y || e.z !== target_z ||
							e.empty !== path_empty || e.ovf !== path_overflowed) begin
						$display("%0t: mismatch exp x=%h y=%h z=%h e=%b o=%b", $time,
							e.x, e.y, e.z, e.empty, e.ovf);
						$display("%0t:          got x=%h y=%h z=%h e=%b o=%b", $time,
							target_x, target_y, target_z, path_empty, path_overflowed);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

// ===== tb/sv/path_point_at_arc_length_tb.sv =====
// ----------------------------------------------------------------------------
// path_point_at_arc_length_tb: regression for path point at arc length
// Directed words on the corners, a full path with overflow, then random
// build-and-query sequences with idling on both sides and a long stall.
// ----------------------------------------------------------------------------
module path_point_at_arc_length_tb;
	import ppal_pkg::*;

	localparam int LIMIT = 4_000_000;   // cycles; slowest run is far below
	localparam int N_ITEMS = 1050;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         operation = OP_NONE;
	logic signed [31:0] point_x = '0;
	logic signed [31:0] point_y = '0;
	logic signed [31:0] point_z = '0;
	logic signed [31:0] query_distance = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] target_x, target_y, target_z;
	logic               path_empty, path_overflowed;

	int fail_count;
	int pending;
	int cycles = 0;
	int words_sent = 0;
	bit quiet = 1'b0;      // no idling in the final stretch
	bit hold_out = 1'b0;   // asks the receiver for a long stall

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	path_point_at_arc_length dut (.*);

	path_point_at_arc_length_chk chk (.*);

	// run watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_out) begin
				out_ready <= 1'b0;
				repeat (600) @(posedge clk);
				hold_out = 1'b0;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(0, 8)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// one word on the input channel; valid stays up across back-to-back words
	task automatic send_word(input op_t op, input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input logic [31:0] d);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		operation      <= op;
		point_x        <= x;
		point_y        <= y;
		point_z        <= z;
		query_distance <= d;
		in_valid       <= 1'b1;
		do @(posedge clk); while (!in_ready);
		words_sent++;
	endtask

	// wait until every query result has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		@(posedge clk);
	endtask

	// point_x/y/z/d are don't-care for the ops that ignore them: randomize
	task automatic send_op(input op_t op);
		send_word(op, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic append(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
		send_word(OP_APPEND, x, y, z, $urandom);
	endtask

	task automatic query(input logic [31:0] d);
		send_word(OP_QUERY, $urandom, $urandom, $urandom, d);
	endtask

	// coordinate within +/- 2^scale, or full range when scale is 31
	function automatic logic [31:0] pick_coord(input int scale);
		logic signed [31:0] v;
		v = $signed($urandom) >>> (31 - scale);
		return v;
	endfunction

	initial begin
		int n_pts, n_q, scale, span;
		logic [31:0] px, py, pz;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners
		query(32'sd5);                          // empty path
		send_op(OP_NONE);                       // unused code: no result
		append(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
		query(32'sd1);                          // one point: past the end
		query(32'h8000_0000);                   // most negative distance
		query(32'sd0);
		append(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000); // widest segment
		query(32'sd1);
		query(32'h4000_0000);
		query(32'h7FFF_FFFF);
		send_op(OP_CLEAR);
		append(32'sd0, 32'sd0, 32'sd0);
		append(32'sd0, 32'sd0, 32'h0001_0000);  // zero planar length
		append(32'h0003_0000, 32'h0004_0000, 32'hFFFF_0000);
		query(32'h0002_8000);                   // half way along the 3-4-5 leg
		query(32'h0005_0000);                   // exactly at the end
		query(32'h0005_0001);
		query(32'hFFFF_FFFF);
		drain();

		// full path, then drops past capacity
		send_op(OP_CLEAR);
		for (int i = 0; i < MAX_POINTS_DEF + 2; i++)
			append(32'(i) << 12, 32'(i % 3) << 10, $urandom);
		query(32'h7FFF_FFFF);
		query(32'h0008_0000);
		drain();

		// random build-and-query sequences
		while (words_sent < N_ITEMS) begin
			if (words_sent > N_ITEMS - 120)
				quiet = 1'b1;
			if (words_sent > 500 && words_sent < 520 && !hold_out) begin
				drain();
				hold_out = 1'b1;        // block fills while results pile up
			end
			if (words_sent > 750 && words_sent < 770)
				drain();                // sender pause until all results are back
			if ($urandom_range(0, 9) != 0)
				send_op(OP_CLEAR);
			scale = ($urandom_range(0, 7) == 0) ? 31 : $urandom_range(4, 24);
			n_pts = $urandom_range(0, 8);
			px = pick_coord(scale);
			py = pick_coord(scale);
			pz = pick_coord(scale);
			for (int i = 0; i < n_pts; i++) begin
				case ($urandom_range(0, 7))
				0: ;                        // repeat the point
				1: pz = pick_coord(scale);  // vertical move only
				default: begin
					px = pick_coord(scale);
					py = pick_coord(scale);
					pz = pick_coord(scale);
				end
				endcase
				append(px, py, pz);
			end
			if ($urandom_range(0, 15) == 0)
				send_op(OP_NONE);
			n_q = $urandom_range(1, 5);
			span = (scale > 28) ? 31 : scale + 5;
			for (int i = 0; i < n_q; i++) begin
				case ($urandom_range(0, 9))
				0: query($urandom);
				1: query(-$urandom_range(0, 1000));
				default: query($urandom_range(0, (1 << span) - 1));
				endcase
			end
		end

		drain();
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
